>>> src/sks_pkg.sv
// Package for the sorted key set: sizes, field types, request codes and
// sequencer states. Depends on nothing; every other file imports it.
package sks_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 16;
    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;
    typedef logic [1:0]          req_t;

    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_DELETE = 2'd1;
    localparam req_t REQ_FIND   = 2'd2;
    localparam req_t REQ_READ   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_ACT,
        ST_UP_RD,
        ST_UP_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_READ_WAIT,
        ST_FINISH
    } st_t;

endpackage

>>> src/sks_ifs.sv
// Channel interfaces of the sorted key set: request, result and marker write.
// Depends on sks_pkg for the field types.
interface sks_req_if;
    import sks_pkg::*;
    logic  valid;
    logic  ready;
    req_t  req_type;
    key_t  key;
    idx_t  rank;
    modport source (output valid, output req_type, output key, output rank, input ready);
    modport sink (input valid, input req_type, input key, input rank, output ready);
endinterface

interface sks_rsp_if;
    import sks_pkg::*;
    logic  valid;
    logic  ready;
    logic  hit;
    key_t  read_value;
    logic  error;
    cnt_t  entry_count;
    logic  marker_present;
    modport source (output valid, output hit, output read_value, output error,
                    output entry_count, output marker_present, input ready);
    modport sink (input valid, input hit, input read_value, input error,
                  input entry_count, input marker_present, output ready);
endinterface

interface sks_cfg_if;
    import sks_pkg::*;
    logic  valid;
    logic  ready;
    key_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/sorted_key_set.sv
// Sorted key set: a sequencer around one key memory and one shared comparator.
// Depends on sks_pkg and the channel interfaces in sks_ifs.sv.
//
//   Channel   Direction   Carries
//   req       in          req_type, key, rank
//   rsp       out         hit, read_value, error, entry_count, marker_present
//   cfg       in          data (empty marker key), always ready
//
// An in-range read reads memory from idle and takes the value in a wait state; a
// read whose rank is not below the count returns an error. Insert, delete and find
// scan memory from rank 0, a read and a compare per entry below the key; insert and
// delete move each shifted entry by a read and a write (one registered read a cycle).
// Reset clears the count, the marker flag and the marker key; memory contents
// are not cleared. The request channel is ready only when the sequencer is
// idle, and a finished word waits in the result register until taken.
module sorted_key_set (
    input  logic      clk,
    input  logic      rst_n,
    sks_req_if.sink   req,
    sks_rsp_if.source rsp,
    sks_cfg_if.sink   cfg
);
    import sks_pkg::*;

    key_t mem [CAPACITY];
    key_t rdata_reg;
    logic mem_re;
    logic mem_we;
    idx_t mem_raddr;
    idx_t mem_waddr;
    key_t mem_wdata;

    st_t  state_reg, state_next;
    req_t op_reg, op_next;
    key_t key_reg, key_next;
    idx_t rank_reg, rank_next;
    cnt_t cur_reg, cur_next;
    cnt_t pos_reg, pos_next;
    cnt_t count_reg, count_next;
    logic flag_reg, flag_next;
    key_t marker_reg;
    logic hit_reg, hit_next;
    logic err_reg, err_next;
    key_t val_reg, val_next;
    logic out_valid_reg, out_valid_next;
    logic out_hit_reg, out_hit_next;
    logic out_err_reg, out_err_next;
    key_t out_val_reg, out_val_next;
    cnt_t out_cnt_reg, out_cnt_next;
    logic out_flag_reg, out_flag_next;

    logic key_less;
    logic key_equal;
    cnt_t cur_inc;

    assign key_less  = rdata_reg < key_reg;
    assign key_equal = rdata_reg == key_reg;
    assign cur_inc   = cnt_t'(cur_reg + cnt_t'(1));

    assign req.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.read_value     = out_val_reg;
    assign rsp.error          = out_err_reg;
    assign rsp.entry_count    = out_cnt_reg;
    assign rsp.marker_present = out_flag_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            marker_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                marker_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        rank_reg     <= rank_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        err_reg      <= err_next;
        val_reg      <= val_next;
        out_hit_reg  <= out_hit_next;
        out_err_reg  <= out_err_next;
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
        out_flag_reg <= out_flag_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rank_next      = rank_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        hit_next       = hit_reg;
        err_next       = err_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_err_next   = out_err_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_flag_next  = out_flag_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_raddr      = cur_reg[IDX_BITS-1:0];
        mem_waddr      = cur_reg[IDX_BITS-1:0];
        mem_wdata      = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.req_type;
                    key_next  = req.key;
                    rank_next = req.rank;
                    cur_next  = '0;
                    hit_next  = 1'b0;
                    err_next  = 1'b0;
                    val_next  = '0;
                    if (req.req_type == REQ_READ)
                    begin
                        if (cnt_t'(req.rank) < count_reg)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = req.rank;
                            state_next = ST_READ_WAIT;
                        end
                        else
                        begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cur_reg >= count_reg)
                begin
                    pos_next   = cur_reg;
                    hit_next   = 1'b0;
                    state_next = ST_ACT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (key_less)
                begin
                    cur_next   = cur_inc;
                    state_next = ST_SCAN;
                end
                else
                begin
                    pos_next   = cur_reg;
                    hit_next   = key_equal;
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                unique case (op_reg)
                    REQ_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (count_reg == cnt_t'(CAPACITY))
                        begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cur_next   = count_reg;
                            state_next = ST_UP_RD;
                        end
                    end
                    REQ_DELETE:
                    begin
                        cur_next   = pos_reg;
                        state_next = hit_reg ? ST_DN_RD : ST_FINISH;
                    end
                    REQ_FIND:
                    begin
                        state_next = ST_FINISH;
                    end
                    REQ_READ:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_UP_RD:
            begin
                if (cur_reg == pos_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = key_reg;
                    count_next = cnt_t'(count_reg + cnt_t'(1));
                    if (key_reg == marker_reg)
                    begin
                        flag_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_t'(cur_reg - cnt_t'(1));
                    state_next = ST_UP_WR;
                end
            end
            ST_UP_WR:
            begin
                mem_we     = 1'b1;
                cur_next   = cnt_t'(cur_reg - cnt_t'(1));
                state_next = ST_UP_RD;
            end
            ST_DN_RD:
            begin
                if (cur_inc >= count_reg)
                begin
                    count_next = cnt_t'(count_reg - cnt_t'(1));
                    if (key_reg == marker_reg)
                    begin
                        flag_next = 1'b0;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_inc[IDX_BITS-1:0];
                    state_next = ST_DN_WR;
                end
            end
            ST_DN_WR:
            begin
                mem_we     = 1'b1;
                cur_next   = cur_inc;
                state_next = ST_DN_RD;
            end
            ST_READ_WAIT:
            begin
                val_next   = rdata_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_err_next   = err_reg;
                    out_val_next   = val_reg;
                    out_cnt_next   = count_reg;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the sorted key set: directed table, then random phases.
// Depends on sks_pkg and the channel interfaces in src/sks_ifs.sv, plus the block itself.
// Typed rows are checked against their table word, the rest against a behavioral copy.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sks_pkg::*;

    typedef struct packed {
        logic hit;
        key_t read_value;
        logic error;
        cnt_t entry_count;
        logic marker_present;
    } set_result_t;

    typedef struct packed {
        req_t        op;
        key_t        k;
        idx_t        r;
        logic        typed;
        set_result_t want;
    } dir_row_t;

    localparam int          CYCLE_LIMIT  = 1_200_000;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          NUM_DIRECTED = 24;
    localparam set_result_t NO_RESULT    = '0;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{REQ_READ,   16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b1, 7'd0, 1'b0}},
        '{REQ_FIND,   16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd0, 1'b0}},
        '{REQ_DELETE, 16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd0, 1'b0}},
        '{REQ_READ,   16'h0000, 6'd63, 1'b1, '{1'b0, 16'h0000, 1'b1, 7'd0, 1'b0}},
        '{REQ_INSERT, 16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd1, 1'b1}},
        '{REQ_INSERT, 16'h0000, 6'd0,  1'b1, '{1'b1, 16'h0000, 1'b0, 7'd1, 1'b1}},
        '{REQ_INSERT, 16'hFFFF, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd2, 1'b1}},
        '{REQ_READ,   16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd2, 1'b1}},
        '{REQ_READ,   16'h0000, 6'd1,  1'b1, '{1'b0, 16'hFFFF, 1'b0, 7'd2, 1'b1}},
        '{REQ_READ,   16'h0000, 6'd2,  1'b1, '{1'b0, 16'h0000, 1'b1, 7'd2, 1'b1}},
        '{REQ_INSERT, 16'h8000, 6'd0,  1'b0, NO_RESULT},
        '{REQ_INSERT, 16'h7FFF, 6'd0,  1'b0, NO_RESULT},
        '{REQ_INSERT, 16'h0001, 6'd0,  1'b0, NO_RESULT},
        '{REQ_READ,   16'h0000, 6'd2,  1'b0, NO_RESULT},
        '{REQ_FIND,   16'hFFFF, 6'd0,  1'b0, NO_RESULT},
        '{REQ_FIND,   16'h8001, 6'd0,  1'b0, NO_RESULT},
        '{REQ_DELETE, 16'h7FFF, 6'd0,  1'b0, NO_RESULT},
        '{REQ_DELETE, 16'h0000, 6'd0,  1'b1, '{1'b1, 16'h0000, 1'b0, 7'd3, 1'b0}},
        '{REQ_DELETE, 16'h0000, 6'd0,  1'b1, '{1'b0, 16'h0000, 1'b0, 7'd3, 1'b0}},
        '{REQ_READ,   16'hFFFF, 6'd63, 1'b1, '{1'b0, 16'h0000, 1'b1, 7'd3, 1'b0}},
        '{REQ_INSERT, 16'hFFFF, 6'd0,  1'b0, NO_RESULT},
        '{REQ_INSERT, 16'h0000, 6'd0,  1'b0, NO_RESULT},
        '{REQ_DELETE, 16'hFFFF, 6'd0,  1'b0, NO_RESULT},
        '{REQ_READ,   16'h0000, 6'd3,  1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    sks_req_if req_ch();
    sks_rsp_if rsp_ch();
    sks_cfg_if cfg_ch();

    sorted_key_set dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    key_t        set_keys [CAPACITY];
    cnt_t        set_count;
    logic        marker_flag;
    key_t        marker_key;
    set_result_t pending_results [$];

    int idle_pct;
    int rsp_stall;
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_seen;
    int full_drops;
    int range_errors;
    int marker_rises;
    int marker_writes;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb_top: %0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic set_result_t apply_request(req_t op, key_t k, idx_t r);
        set_result_t res;
        int          pos;
        int          j;
        bit          present;
        res = '0;
        if (op == REQ_READ)
        begin
            if (r < set_count)
                res.read_value = set_keys[r];
            else
            begin
                res.error = 1'b1;
                range_errors++;
            end
        end
        else
        begin
            pos = 0;
            while (pos < set_count && set_keys[pos] < k)
                pos++;
            present = (pos < set_count) && (set_keys[pos] == k);
            case (op)
                REQ_INSERT:
                begin
                    if (present)
                        res.hit = 1'b1;
                    else if (set_count >= CAPACITY)
                    begin
                        res.error = 1'b1;
                        full_drops++;
                    end
                    else
                    begin
                        for (j = int'(set_count); j > pos; j--)
                            set_keys[j] = set_keys[j-1];
                        set_keys[pos] = k;
                        set_count++;
                        if (k == marker_key)
                        begin
                            if (!marker_flag)
                                marker_rises++;
                            marker_flag = 1'b1;
                        end
                    end
                end
                REQ_DELETE:
                begin
                    if (present)
                    begin
                        res.hit = 1'b1;
                        for (j = pos; j + 1 < set_count; j++)
                            set_keys[j] = set_keys[j+1];
                        set_count--;
                        if (k == marker_key)
                            marker_flag = 1'b0;
                    end
                end
                default:
                    res.hit = present;
            endcase
        end
        res.entry_count    = set_count;
        res.marker_present = marker_flag;
        return res;
    endfunction

    task automatic send_request(req_t op, key_t k, idx_t r, logic typed, set_result_t want);
        int          gap;
        set_result_t predicted;
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key      <= k;
        req_ch.rank     <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_request(op, k, r);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic stop_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_marker(key_t value);
        stop_requests();
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        marker_key = value;
        marker_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(key_t lo, int span, int ins_w, int del_w, int find_w, int n_items);
        int   i;
        int   pick;
        req_t op;
        key_t k;
        idx_t r;
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < ins_w)
                op = REQ_INSERT;
            else if (pick < ins_w + del_w)
                op = REQ_DELETE;
            else if (pick < ins_w + del_w + find_w)
                op = REQ_FIND;
            else
                op = REQ_READ;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                k = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            else if (pick < 55 && set_count != 0)
                k = set_keys[$urandom_range(0, int'(set_count) - 1)];
            else
                k = key_t'(lo + $urandom_range(0, span - 1));
            if ($urandom_range(0, 99) < 30)
                r = idx_t'($urandom_range(0, 63));
            else
                r = idx_t'($urandom_range(0, (set_count > 63) ? 63 : int'(set_count)));
            send_request(op, k, r, 1'b0, NO_RESULT);
        end
    endtask

    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = $urandom_range(0, 3);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected word, entry_count",
                                32'(rsp_ch.entry_count), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch("hit", 32'(rsp_ch.hit), 32'(want.hit));
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch("read_value", 32'(rsp_ch.read_value),
                                    32'(want.read_value));
                if (rsp_ch.error !== want.error)
                    report_mismatch("error", 32'(rsp_ch.error), 32'(want.error));
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_ch.entry_count),
                                    32'(want.entry_count));
                if (rsp_ch.marker_present !== want.marker_present)
                    report_mismatch("marker_present", 32'(rsp_ch.marker_present),
                                    32'(want.marker_present));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        int   d;
        key_t lo;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key      = '0;
        req_ch.rank     = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        set_count       = '0;
        marker_flag     = 1'b0;
        marker_key      = '0;
        idle_pct        = 25;
        rsp_stall       = 0;
        cycle_count     = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_seen    = 0;
        full_drops      = 0;
        range_errors    = 0;
        marker_rises    = 0;
        marker_writes   = 0;
        for (d = 0; d < CAPACITY; d++)
            set_keys[d] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (d = 0; d < NUM_DIRECTED; d++)
            send_request(DIRECTED[d].op, DIRECTED[d].k, DIRECTED[d].r,
                         DIRECTED[d].typed, DIRECTED[d].want);

        // The marker moves while keys are held; the flag must keep its value.
        idle_pct = 25;
        write_marker(16'hFFFF);
        run_phase(16'hFF9C, 100, 70, 5, 15, 150);

        idle_pct = 40;
        lo = key_t'($urandom_range(0, 65535 - 80));
        write_marker(key_t'(lo + $urandom_range(0, 79)));
        run_phase(lo, 80, 35, 35, 15, 200);

        idle_pct = 0;
        write_marker(16'h0000);
        run_phase(16'h0000, 90, 15, 60, 10, 150);

        idle_pct = 25;
        write_marker(key_t'($urandom_range(0, 65535)));
        run_phase(16'h0000, 65536, 40, 25, 15, 150);

        idle_pct = 0;
        write_marker(16'h8000);
        run_phase(16'h7FD8, 80, 40, 30, 15, 150);

        stop_requests();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d requests sent, %0d result words checked, %0d marker writes",
                 requests_sent, results_seen, marker_writes);
        $display("tb_top: %0d inserts into a full set, %0d out-of-range reads, %0d marker rises",
                 full_drops, range_errors, marker_rises);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
src/sks_pkg.sv
src/sks_ifs.sv
src/sorted_key_set.sv
dv/tb_top.sv
